>>> rtl/qsd_pkg.sv
// ----------------------------------------------------------------------------
// qsd_pkg
// shared widths and types of the quad shape derivative datapath
// ----------------------------------------------------------------------------
package qsd_pkg;

    // local derivative terms, four times dN/dr and dN/ds in Q.14
    localparam int G_W    = 18;
    localparam int QONE   = 16384;
    // one product of a derivative term and a coordinate
    localparam int P_W    = 50;
    // jacobian entries
    localparam int J_W    = 52;
    localparam int JL_W   = 26;
    localparam int JH_W   = J_W - JL_W;
    // partial products of the split multiplications
    localparam int DP_W   = 54;
    localparam int NP_W   = 46;
    // determinant and numerators
    localparam int DET_W  = 104;
    localparam int NUM_W  = 72;
    // quotient bits and divider remainder
    localparam int Q_W    = 32;
    localparam int RW     = DET_W + Q_W;
    // four dN/dx lanes followed by four dN/dy lanes
    localparam int LANES  = 8;
    localparam int NODES  = 4;

    localparam logic [Q_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] SAT_MIN = 32'h8000_0000;

    // data that rides along with the divider lanes
    typedef struct packed {
        logic             zero;
        logic [Q_W-1:0]   det_sat;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } side_t;

    // pipeline control handed to the divider
    typedef struct packed {
        logic vld;
        logic adv;
    } ctl_t;

endpackage

>>> rtl/qsd_div.sv
// ----------------------------------------------------------------------------
// qsd_div
// pipelined restoring divider, one quotient bit per stage, eight lanes
// ----------------------------------------------------------------------------
module qsd_div
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  qsd_pkg::ctl_t                             ctl,
    input  logic [qsd_pkg::LANES-1:0][qsd_pkg::RW-1:0] rem_in,
    input  logic [qsd_pkg::DET_W-1:0]                 den_in,
    input  qsd_pkg::side_t                            side_in,
    output logic                                      vld_out,
    output logic [qsd_pkg::LANES-1:0][qsd_pkg::Q_W-1:0] q_out,
    output qsd_pkg::side_t                            side_out
);

    localparam int STAGES = qsd_pkg::Q_W;

    logic                         vld_reg  [STAGES];
    logic [qsd_pkg::RW-1:0]       rem_reg  [STAGES-1][qsd_pkg::LANES];
    logic [qsd_pkg::DET_W-1:0]    den_reg  [STAGES-1];
    logic [qsd_pkg::Q_W-1:0]      q_reg    [STAGES][qsd_pkg::LANES];
    qsd_pkg::side_t               side_reg [STAGES];

    genvar k, l;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            logic                      vld_p;
            logic [qsd_pkg::RW-1:0]    rem_p  [qsd_pkg::LANES];
            logic [qsd_pkg::DET_W-1:0] den_p;
            logic [qsd_pkg::Q_W-1:0]   q_p    [qsd_pkg::LANES];
            qsd_pkg::side_t            side_p;
            logic [qsd_pkg::RW-1:0]    sub;
            logic [qsd_pkg::RW-1:0]    rem_next [qsd_pkg::LANES];
            logic [qsd_pkg::Q_W-1:0]   q_next   [qsd_pkg::LANES];

            if (k == 0) begin : g_first
                assign vld_p  = ctl.vld;
                assign den_p  = den_in;
                assign side_p = side_in;
                for (l = 0; l < qsd_pkg::LANES; l++) begin : g_in
                    assign rem_p[l] = rem_in[l];
                    assign q_p[l]   = '0;
                end
            end else begin : g_mid
                assign vld_p  = vld_reg[k-1];
                assign den_p  = den_reg[k-1];
                assign side_p = side_reg[k-1];
                for (l = 0; l < qsd_pkg::LANES; l++) begin : g_in
                    assign rem_p[l] = rem_reg[k-1][l];
                    assign q_p[l]   = q_reg[k-1][l];
                end
            end

            // divisor aligned to this stage's quotient bit
            assign sub = qsd_pkg::RW'(den_p) << (STAGES - 1 - k);

            always_comb
            begin
                for (int i = 0; i < qsd_pkg::LANES; i++)
                begin
                    if (rem_p[i] >= sub)
                    begin
                        rem_next[i] = rem_p[i] - sub;
                        q_next[i]   = {q_p[i][qsd_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = rem_p[i];
                        q_next[i]   = {q_p[i][qsd_pkg::Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (ctl.adv)
                begin
                    vld_reg[k] <= vld_p;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.adv)
                begin
                    side_reg[k] <= side_p;
                    for (int i = 0; i < qsd_pkg::LANES; i++)
                    begin
                        q_reg[k][i] <= q_next[i];
                    end
                end
            end

            // the last stage keeps the quotient, valid bit and side data, but no remainder or divisor
            if (k < STAGES - 1) begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (ctl.adv)
                    begin
                        den_reg[k] <= den_p;
                        for (int i = 0; i < qsd_pkg::LANES; i++)
                        begin
                            rem_reg[k][i] <= rem_next[i];
                        end
                    end
                end
            end
        end

        for (l = 0; l < qsd_pkg::LANES; l++) begin : g_out
            assign q_out[l] = q_reg[STAGES-1][l];
        end
    endgenerate

    assign vld_out  = vld_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

>>> rtl/quad_shape_derivatives_core.sv
// ----------------------------------------------------------------------------
// quad_shape_derivatives_core
// global shape function derivatives and jacobian determinant of a bilinear
// quad element at one gauss point
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled; the 32-stage divider array sets the depth
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
// reset clears all valid bits at once; payload registers are not reset
// ----------------------------------------------------------------------------
module quad_shape_derivatives_core
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] r_coord,
    input  logic signed [15:0] s_coord,
    input  logic signed [31:0] node_x0,
    input  logic signed [31:0] node_y0,
    input  logic signed [31:0] node_x1,
    input  logic signed [31:0] node_y1,
    input  logic signed [31:0] node_x2,
    input  logic signed [31:0] node_y2,
    input  logic signed [31:0] node_x3,
    input  logic signed [31:0] node_y3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] dndx_0,
    output logic signed [31:0] dndx_1,
    output logic signed [31:0] dndx_2,
    output logic signed [31:0] dndx_3,
    output logic signed [31:0] dndy_0,
    output logic signed [31:0] dndy_1,
    output logic signed [31:0] dndy_2,
    output logic signed [31:0] dndy_3,
    output logic signed [31:0] jacobian_det,
    output logic               singular
);

    localparam int G_W   = qsd_pkg::G_W;
    localparam int P_W   = qsd_pkg::P_W;
    localparam int J_W   = qsd_pkg::J_W;
    localparam int JL_W  = qsd_pkg::JL_W;
    localparam int JH_W  = qsd_pkg::JH_W;
    localparam int DP_W  = qsd_pkg::DP_W;
    localparam int NP_W  = qsd_pkg::NP_W;
    localparam int DET_W = qsd_pkg::DET_W;
    localparam int NUM_W = qsd_pkg::NUM_W;
    localparam int Q_W   = qsd_pkg::Q_W;
    localparam int RW    = qsd_pkg::RW;
    localparam int LANES = qsd_pkg::LANES;
    localparam int NODES = qsd_pkg::NODES;
    // det carries 2^(28+2F) scale times 16, so the output shift is 32+F
    localparam int DET_SH = Q_W + COORD_FRAC_BITS;
    localparam int NUM_SH = 2 * COORD_FRAC_BITS;

    // ------------------------------------------------------------------
    // global advance: the pipeline moves unless a result waits stalled
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // stage 1: local derivative rows and coordinate products
    // ------------------------------------------------------------------
    logic signed [G_W-1:0] gr [NODES];
    logic signed [G_W-1:0] gs [NODES];
    logic signed [31:0]    xin [NODES];
    logic signed [31:0]    yin [NODES];
    logic signed [G_W-1:0] rr, ss;

    assign xin[0] = node_x0;
    assign xin[1] = node_x1;
    assign xin[2] = node_x2;
    assign xin[3] = node_x3;
    assign yin[0] = node_y0;
    assign yin[1] = node_y1;
    assign yin[2] = node_y2;
    assign yin[3] = node_y3;

    assign rr = G_W'(r_coord);
    assign ss = G_W'(s_coord);

    // nodes counter-clockwise from (+1,+1)
    assign gr[0] = G_W'(qsd_pkg::QONE) + ss;
    assign gr[1] = -(G_W'(qsd_pkg::QONE) + ss);
    assign gr[2] = ss - G_W'(qsd_pkg::QONE);
    assign gr[3] = G_W'(qsd_pkg::QONE) - ss;
    assign gs[0] = G_W'(qsd_pkg::QONE) + rr;
    assign gs[1] = G_W'(qsd_pkg::QONE) - rr;
    assign gs[2] = rr - G_W'(qsd_pkg::QONE);
    assign gs[3] = -(G_W'(qsd_pkg::QONE) + rr);

    logic                  v1_reg;
    logic signed [G_W-1:0] gr1_reg [NODES];
    logic signed [G_W-1:0] gs1_reg [NODES];
    logic signed [P_W-1:0] prx_reg [NODES];
    logic signed [P_W-1:0] pry_reg [NODES];
    logic signed [P_W-1:0] psx_reg [NODES];
    logic signed [P_W-1:0] psy_reg [NODES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                gr1_reg[i] <= gr[i];
                gs1_reg[i] <= gs[i];
                prx_reg[i] <= gr[i] * xin[i];
                pry_reg[i] <= gr[i] * yin[i];
                psx_reg[i] <= gs[i] * xin[i];
                psy_reg[i] <= gs[i] * yin[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: jacobian entries (scaled by 4 * 2^14)
    // ------------------------------------------------------------------
    logic                  v2_reg;
    logic signed [G_W-1:0] gr2_reg [NODES];
    logic signed [G_W-1:0] gs2_reg [NODES];
    logic signed [J_W-1:0] j00_reg, j01_reg, j10_reg, j11_reg;
    logic signed [J_W-1:0] j00_next, j01_next, j10_next, j11_next;

    always_comb
    begin
        j00_next = '0;
        j01_next = '0;
        j10_next = '0;
        j11_next = '0;
        for (int i = 0; i < NODES; i++)
        begin
            j00_next = j00_next + J_W'(prx_reg[i]);
            j01_next = j01_next + J_W'(pry_reg[i]);
            j10_next = j10_next + J_W'(psx_reg[i]);
            j11_next = j11_next + J_W'(psy_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j00_reg <= j00_next;
            j01_reg <= j01_next;
            j10_reg <= j10_next;
            j11_reg <= j11_next;
            for (int i = 0; i < NODES; i++)
            begin
                gr2_reg[i] <= gr1_reg[i];
                gs2_reg[i] <= gs1_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: split partial products of det and the eight numerators
    // ------------------------------------------------------------------
    logic signed [JH_W-1:0] j00h, j01h, j10h, j11h;
    logic signed [JL_W:0]   j00l, j01l, j10l, j11l;

    assign j00h = j00_reg[J_W-1:JL_W];
    assign j01h = j01_reg[J_W-1:JL_W];
    assign j10h = j10_reg[J_W-1:JL_W];
    assign j11h = j11_reg[J_W-1:JL_W];
    assign j00l = $signed({1'b0, j00_reg[JL_W-1:0]});
    assign j01l = $signed({1'b0, j01_reg[JL_W-1:0]});
    assign j10l = $signed({1'b0, j10_reg[JL_W-1:0]});
    assign j11l = $signed({1'b0, j11_reg[JL_W-1:0]});

    // lane numerator = ja * ga - jb * gb
    logic signed [JH_W-1:0] jah [LANES];
    logic signed [JL_W:0]   jal [LANES];
    logic signed [JH_W-1:0] jbh [LANES];
    logic signed [JL_W:0]   jbl [LANES];
    logic signed [G_W-1:0]  ga  [LANES];
    logic signed [G_W-1:0]  gb  [LANES];

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            // dN/dx: j11 * gr - j01 * gs
            jah[i] = j11h;
            jal[i] = j11l;
            jbh[i] = j01h;
            jbl[i] = j01l;
            ga[i]  = gr2_reg[i];
            gb[i]  = gs2_reg[i];
            // dN/dy: j00 * gs - j10 * gr
            jah[NODES+i] = j00h;
            jal[NODES+i] = j00l;
            jbh[NODES+i] = j10h;
            jbl[NODES+i] = j10l;
            ga[NODES+i]  = gs2_reg[i];
            gb[NODES+i]  = gr2_reg[i];
        end
    end

    logic                   v3_reg;
    logic signed [DP_W-1:0] dhh_reg [2];
    logic signed [DP_W-1:0] dhl_reg [2];
    logic signed [DP_W-1:0] dlh_reg [2];
    logic signed [DP_W-1:0] dll_reg [2];
    logic signed [NP_W-1:0] pah_reg [LANES];
    logic signed [NP_W-1:0] pal_reg [LANES];
    logic signed [NP_W-1:0] pbh_reg [LANES];
    logic signed [NP_W-1:0] pbl_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // term 0 is j00 * j11, term 1 is j01 * j10
            dhh_reg[0] <= j00h * j11h;
            dhl_reg[0] <= j00h * j11l;
            dlh_reg[0] <= j00l * j11h;
            dll_reg[0] <= j00l * j11l;
            dhh_reg[1] <= j01h * j10h;
            dhl_reg[1] <= j01h * j10l;
            dlh_reg[1] <= j01l * j10h;
            dll_reg[1] <= j01l * j10l;
            for (int i = 0; i < LANES; i++)
            begin
                pah_reg[i] <= jah[i] * ga[i];
                pal_reg[i] <= jal[i] * ga[i];
                pbh_reg[i] <= jbh[i] * gb[i];
                pbl_reg[i] <= jbl[i] * gb[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: recombine determinant and numerators
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] dterm [2];
    logic signed [DET_W-1:0] det_next;
    logic signed [NUM_W-1:0] num_next [LANES];

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            dterm[t] = (DET_W'(dhh_reg[t]) <<< (2 * JL_W))
                     + ((DET_W'(dhl_reg[t]) + DET_W'(dlh_reg[t])) <<< JL_W)
                     + DET_W'(dll_reg[t]);
        end
        det_next = dterm[0] - dterm[1];
        for (int i = 0; i < LANES; i++)
        begin
            num_next[i] = ((NUM_W'(pah_reg[i]) - NUM_W'(pbh_reg[i])) <<< JL_W)
                        + NUM_W'(pal_reg[i]) - NUM_W'(pbl_reg[i]);
        end
    end

    logic                    v4_reg;
    logic signed [DET_W-1:0] det4_reg;
    logic signed [NUM_W-1:0] num4_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det4_reg <= det_next;
            for (int i = 0; i < LANES; i++)
            begin
                num4_reg[i] <= num_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: magnitudes, zero test, saturated determinant
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] det_sh;
    logic                    det_fits;
    logic [Q_W-1:0]          det_sat_next;

    assign det_sh   = det4_reg >>> DET_SH;
    assign det_fits = (&det_sh[DET_W-1:Q_W-1]) | ~(|det_sh[DET_W-1:Q_W-1]);

    always_comb
    begin
        if (det_fits)
        begin
            det_sat_next = det_sh[Q_W-1:0];
        end
        else if (det_sh[DET_W-1])
        begin
            det_sat_next = qsd_pkg::SAT_MIN;
        end
        else
        begin
            det_sat_next = qsd_pkg::SAT_MAX;
        end
    end

    logic                v5_reg;
    logic [DET_W-1:0]    dabs5_reg;
    logic                dneg5_reg;
    logic                zero5_reg;
    logic [Q_W-1:0]      dsat5_reg;
    logic [NUM_W-1:0]    nabs5_reg [LANES];
    logic [LANES-1:0]    nneg5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dabs5_reg <= det4_reg[DET_W-1] ? DET_W'(-det4_reg) : det4_reg;
            dneg5_reg <= det4_reg[DET_W-1];
            zero5_reg <= (det4_reg == '0);
            dsat5_reg <= det_sat_next;
            for (int i = 0; i < LANES; i++)
            begin
                nabs5_reg[i] <= num4_reg[i][NUM_W-1] ? NUM_W'(-num4_reg[i]) : num4_reg[i];
                nneg5_reg[i] <= num4_reg[i][NUM_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: scale numerators, quotient overflow test (q >= 2^32)
    // ------------------------------------------------------------------
    logic [RW-1:0] den_wide;
    logic [RW-1:0] a_next [LANES];

    assign den_wide = {dabs5_reg, {Q_W{1'b0}}};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            a_next[i] = RW'(nabs5_reg[i]) << NUM_SH;
        end
    end

    logic                            v6_reg;
    logic [LANES-1:0][RW-1:0]        a6_reg;
    logic [DET_W-1:0]                dabs6_reg;
    qsd_pkg::side_t                  side6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dabs6_reg         <= dabs5_reg;
            side6_reg.zero    <= zero5_reg;
            side6_reg.det_sat <= dsat5_reg;
            for (int i = 0; i < LANES; i++)
            begin
                a6_reg[i]        <= a_next[i];
                side6_reg.neg[i] <= nneg5_reg[i] ^ dneg5_reg;
                side6_reg.ovf[i] <= (a_next[i] >= den_wide);
            end
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // 32-stage divider, one quotient bit per stage for all eight lanes
    // ------------------------------------------------------------------
    qsd_pkg::ctl_t                   div_ctl;
    logic                            div_vld;
    logic [LANES-1:0][Q_W-1:0]       div_q;
    qsd_pkg::side_t                  div_side;

    assign div_ctl.vld = v6_reg;
    assign div_ctl.adv = adv;

    qsd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_in   (a6_reg),
        .den_in   (dabs6_reg),
        .side_in  (side6_reg),
        .vld_out  (div_vld),
        .q_out    (div_q),
        .side_out (div_side)
    );

    // ------------------------------------------------------------------
    // output stage: sign, saturation, singular override
    // ------------------------------------------------------------------
    logic [Q_W-1:0] res_next [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (div_side.zero)
            begin
                res_next[i] = '0;
            end
            else if (!div_side.neg[i])
            begin
                res_next[i] = (div_side.ovf[i] || div_q[i][Q_W-1]) ? qsd_pkg::SAT_MAX
                                                                   : div_q[i];
            end
            else
            begin
                res_next[i] = (div_side.ovf[i] || (div_q[i] > qsd_pkg::SAT_MIN))
                            ? qsd_pkg::SAT_MIN : Q_W'(-div_q[i]);
            end
        end
    end

    logic [Q_W-1:0] res_reg [LANES];
    logic [Q_W-1:0] det_out_reg;
    logic           singular_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_out_reg  <= div_side.zero ? '0 : div_side.det_sat;
            singular_reg <= div_side.zero;
            for (int i = 0; i < LANES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign dndx_0       = $signed(res_reg[0]);
    assign dndx_1       = $signed(res_reg[1]);
    assign dndx_2       = $signed(res_reg[2]);
    assign dndx_3       = $signed(res_reg[3]);
    assign dndy_0       = $signed(res_reg[4]);
    assign dndy_1       = $signed(res_reg[5]);
    assign dndy_2       = $signed(res_reg[6]);
    assign dndy_3       = $signed(res_reg[7]);
    assign jacobian_det = $signed(det_out_reg);
    assign singular     = singular_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a singular element never leaves a nonzero determinant or a nonzero derivative in lanes 0, 3, 4 and 7
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && singular_reg |->
            (det_out_reg == '0) && (res_reg[0] == '0) && (res_reg[4] == '0)
            && (res_reg[3] == '0) && (res_reg[7] == '0))
        else $error("singular result with nonzero field");

    // no item enters the pipeline without an input transfer
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !in_valid |=> !v1_reg)
        else $error("stage 1 valid without input transfer");

    // a frozen pipeline keeps the stage 6 valid bit and the divider output valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v6_reg) && $stable(div_vld))
        else $error("pipeline moved while stalled");

endmodule
